@@ hw/rtl/bffa_pkg.sv @@
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared constants, types and helpers of the bitmap first-free allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int MAP_BITS    = 8192;
    localparam int WORD_BITS   = 32;
    localparam int POOL_WORDS  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int STORE_WORDS = 2 * POOL_WORDS;
    localparam int WORD_AW     = $clog2(POOL_WORDS);
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int POS_W       = $clog2(WORD_BITS);
    localparam int IDX_W       = 13;
    localparam int CNT_W       = 14;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] CFG_RESET   = CNT_W'(8192);
    localparam logic [CNT_W-1:0] MAP_BITS_C  = CNT_W'(MAP_BITS);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_TEST  = 2'd1,
        OP_SET   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INODE_LIMIT  = 2'd0,
        REG_BLOCK_LIMIT  = 2'd1,
        REG_FREE_INODES  = 2'd2,
        REG_FREE_BLOCKS  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_BIT
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0] inode_limit;
        logic [CNT_W-1:0] block_limit;
        logic [CNT_W-1:0] initial_free_inodes;
        logic [CNT_W-1:0] initial_free_blocks;
    } cfg_t;

    // bit position of a one-hot word
    function automatic logic [POS_W-1:0] onehot_pos(input logic [WORD_BITS-1:0] oh);
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (oh[i])
            begin
                pos = pos | POS_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

@@ hw/rtl/bitmap_first_free_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// First-fit allocator over an inode bitmap and a block bitmap.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the bitmap memory with
// busy high; configuration writes are taken during it. A transaction is
// taken when start is high and busy is low, and its result appears for one
// cycle with done. Test, set and clear read the addressed word in the bit
// state, where set and clear write it back. Allocate reads one 32-bit bitmap
// word per cycle from the single read port of the bitmap memory, up to the
// first free bit or the word that holds the limit; with a limit of zero it
// finishes without a scan.
// Results cannot be held off by the receiver.
module bitmap_first_free_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [bffa_pkg::OP_W-1:0]      op,
    input  logic                           pool,
    input  logic [bffa_pkg::IDX_W-1:0]     bit_index,
    output logic                           done,
    output logic [bffa_pkg::CNT_W-1:0]     alloc_number,
    output logic                           found,
    output logic                           bit_value,
    output logic [bffa_pkg::CNT_W-1:0]     free_left,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bffa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bffa_pkg::CNT_W-1:0]     cfg_data
);
    import bffa_pkg::*;

    cfg_t                 cfg;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    bffa_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bffa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bffa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .pool         (pool),
        .bit_index    (bit_index),
        .done         (done),
        .alloc_number (alloc_number),
        .found        (found),
        .bit_value    (bit_value),
        .free_left    (free_left),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

endmodule

@@ hw/rtl/bffa_ram.sv @@
// ----------------------------------------------------------------------------
// bffa_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module bffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/bffa_cfg.sv @@
// ----------------------------------------------------------------------------
// bffa_cfg
// Configuration register file: pool limits and initial free counts.
// ----------------------------------------------------------------------------
module bffa_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bffa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bffa_pkg::CNT_W-1:0]     cfg_data,
    output bffa_pkg::cfg_t                 cfg
);
    import bffa_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_INODE_LIMIT: cfg_next.inode_limit         = cfg_data;
                REG_BLOCK_LIMIT: cfg_next.block_limit         = cfg_data;
                REG_FREE_INODES: cfg_next.initial_free_inodes = cfg_data;
                REG_FREE_BLOCKS: cfg_next.initial_free_blocks = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inode_limit         <= CFG_RESET;
            cfg_reg.block_limit         <= CFG_RESET;
            cfg_reg.initial_free_inodes <= CFG_RESET;
            cfg_reg.initial_free_blocks <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/bffa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer around the bitmap memory: clearing pass, first-free scan,
// single-bit read-modify-write, allocation counters and result registers.
// ----------------------------------------------------------------------------
module bffa_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bffa_pkg::cfg_t                 cfg,
    input  logic                           start,
    output logic                           busy,
    input  logic [bffa_pkg::OP_W-1:0]      op,
    input  logic                           pool,
    input  logic [bffa_pkg::IDX_W-1:0]     bit_index,
    output logic                           done,
    output logic [bffa_pkg::CNT_W-1:0]     alloc_number,
    output logic                           found,
    output logic                           bit_value,
    output logic [bffa_pkg::CNT_W-1:0]     free_left,
    output logic                           ram_we,
    output logic [bffa_pkg::ADDR_W-1:0]    ram_waddr,
    output logic [bffa_pkg::WORD_BITS-1:0] ram_wdata,
    output logic [bffa_pkg::ADDR_W-1:0]    ram_raddr,
    input  logic [bffa_pkg::WORD_BITS-1:0] ram_rdata
);
    import bffa_pkg::*;

    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};
    localparam logic [POS_W-1:0]     TOP_POS = POS_W'(WORD_BITS - 1);

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    op_t                   op_reg;
    logic                  pool_reg;
    logic [WORD_AW-1:0]    word_reg, word_next;
    logic [POS_W-1:0]      pos_reg;
    logic [WORD_AW-1:0]    last_word_reg;
    logic [WORD_BITS-1:0]  last_mask_reg;
    logic [CNT_W-1:0]      inode_allocs_reg, inode_allocs_next;
    logic [CNT_W-1:0]      block_allocs_reg, block_allocs_next;

    logic                  done_reg;
    logic [CNT_W-1:0]      alloc_number_reg;
    logic                  found_reg;
    logic                  bit_value_reg;
    logic [CNT_W-1:0]      free_left_reg;

    logic                  capture;
    logic                  fin;
    logic                  fin_found;
    logic [CNT_W-1:0]      fin_number;
    logic                  fin_value;
    logic                  fin_pool;

    logic [CNT_W-1:0]      lim_raw;
    logic [CNT_W-1:0]      lim_clip;
    logic [CNT_W-1:0]      lim_m1;
    logic [WORD_AW-1:0]    in_word;
    logic [WORD_BITS-1:0]  cand;
    logic [WORD_BITS-1:0]  iso;
    logic [WORD_BITS-1:0]  bit_mask;

    logic [CNT_W-1:0]      sel_allocs;
    logic [CNT_W-1:0]      allocs_after;
    logic [CNT_W-1:0]      init_sel;

    assign lim_raw  = pool ? cfg.block_limit : cfg.inode_limit;
    assign lim_clip = (lim_raw > MAP_BITS_C) ? MAP_BITS_C : lim_raw;
    assign lim_m1   = lim_clip - CNT_W'(1);
    assign in_word  = bit_index[IDX_W-1:POS_W];

    assign cand     = ~ram_rdata & ((word_reg == last_word_reg) ? last_mask_reg : ONES);
    assign iso      = cand & (~cand + WORD_BITS'(1));
    assign bit_mask = ONES & (WORD_BITS'(1) << pos_reg);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        word_next     = word_reg;
        capture       = 1'b0;
        fin           = 1'b0;
        fin_found     = 1'b0;
        fin_number    = '0;
        fin_value     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = {pool_reg, word_reg};
        ram_wdata     = ram_rdata;
        ram_raddr     = {pool_reg, WORD_AW'(word_reg + 1'b1)};

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(STORE_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    capture = 1'b1;
                    if (op_t'(op) == OP_ALLOC)
                    begin
                        ram_raddr = {pool, {WORD_AW{1'b0}}};
                        word_next = '0;
                        if (lim_clip == '0)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        ram_raddr  = {pool, in_word};
                        word_next  = in_word;
                        state_next = ST_BIT;
                    end
                end
            end
            ST_SCAN:
            begin
                if (|cand)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata | iso;
                    fin        = 1'b1;
                    fin_found  = 1'b1;
                    fin_number = {1'b0, word_reg, onehot_pos(iso)} + CNT_W'(1);
                    state_next = ST_IDLE;
                end
                else if (word_reg == last_word_reg)
                begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                end
            end
            ST_BIT:
            begin
                fin        = 1'b1;
                state_next = ST_IDLE;
                case (op_reg)
                    OP_TEST:  fin_value = ram_rdata[pos_reg];
                    OP_SET:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata | bit_mask;
                    end
                    OP_CLEAR:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata & ~bit_mask;
                    end
                    default:  fin_value = 1'b0;
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // allocation counters and free count of the finishing transaction
    always_comb
    begin
        fin_pool          = (state_reg == ST_IDLE) ? pool : pool_reg;
        sel_allocs        = fin_pool ? block_allocs_reg : inode_allocs_reg;
        init_sel          = fin_pool ? cfg.initial_free_blocks : cfg.initial_free_inodes;
        allocs_after      = sel_allocs;
        if (fin_found && (sel_allocs != CNT_MAX))
        begin
            allocs_after = sel_allocs + CNT_W'(1);
        end
        inode_allocs_next = inode_allocs_reg;
        block_allocs_next = block_allocs_reg;
        if (fin)
        begin
            if (fin_pool)
            begin
                block_allocs_next = allocs_after;
            end
            else
            begin
                inode_allocs_next = allocs_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            inode_allocs_reg <= '0;
            block_allocs_reg <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            inode_allocs_reg <= inode_allocs_next;
            block_allocs_reg <= block_allocs_next;
            done_reg         <= fin;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (capture)
        begin
            op_reg        <= op_t'(op);
            pool_reg      <= pool;
            pos_reg       <= bit_index[POS_W-1:0];
            last_word_reg <= lim_m1[IDX_W-1:POS_W];
            last_mask_reg <= ONES >> (TOP_POS - lim_m1[POS_W-1:0]);
        end
        if (fin)
        begin
            alloc_number_reg <= fin_number;
            found_reg        <= fin_found;
            bit_value_reg    <= fin_value;
            free_left_reg    <= (init_sel > allocs_after) ? (init_sel - allocs_after) : '0;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign alloc_number = alloc_number_reg;
    assign found        = found_reg;
    assign bit_value    = bit_value_reg;
    assign free_left    = free_left_reg;

endmodule

@@ hw/rtl/bffa_checker.sv @@
// ----------------------------------------------------------------------------
// bffa_checker
// Port-level checks of the allocator results, bound to the top level.
// ----------------------------------------------------------------------------
module bffa_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       busy,
    input  logic                       done,
    input  logic [bffa_pkg::CNT_W-1:0] alloc_number,
    input  logic                       found,
    input  logic                       bit_value
);
    import bffa_pkg::*;

    // a found allocation carries a number inside the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (alloc_number != '0) && (alloc_number <= MAP_BITS_C))
    else $error("found allocation with number out of range");

    // no allocation means a zero number
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (alloc_number == '0))
    else $error("nonzero number without allocation");

    // a test result never comes with an allocation
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && bit_value) |-> !found)
    else $error("bit value and found both set");

    // a transaction result leaves the block ready for the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
    else $error("busy while a result is shown");

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .done         (done),
    .alloc_number (alloc_number),
    .found        (found),
    .bit_value    (bit_value)
);

@@ tb/sv/alloc_scoreboard_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alloc_scoreboard_pkg
// Bitmap and counter tracker for the first-free allocator. Every accepted
// request transaction is applied to a local copy of both pool bitmaps, the
// allocation counters and the configuration, which yields the expected
// result. Results from the block are matched in order against that queue.
// ----------------------------------------------------------------------------
package alloc_scoreboard_pkg;

    import bffa_pkg::*;

    typedef struct packed {
        logic [CNT_W-1:0] alloc_number;
        logic             found;
        logic             bit_value;
        logic [CNT_W-1:0] free_left;
    } alloc_result_t;

    class alloc_scoreboard;

        logic [WORD_BITS-1:0] map_words [STORE_WORDS];
        logic [CNT_W-1:0]     alloc_count [2];
        logic [CNT_W-1:0]     search_limit [2];
        logic [CNT_W-1:0]     free_base [2];
        alloc_result_t        pending_results [$];
        int                   errors;

        function new();
            foreach (map_words[w])
            begin
                map_words[w] = '0;
            end
            alloc_count[0]  = '0;
            alloc_count[1]  = '0;
            search_limit[0] = CFG_RESET;
            search_limit[1] = CFG_RESET;
            free_base[0]    = CFG_RESET;
            free_base[1]    = CFG_RESET;
            errors          = 0;
        endfunction

        function int word_addr(logic sel, int bit_pos);
            return int'(sel) * POOL_WORDS + bit_pos / WORD_BITS;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CNT_W-1:0] data);
            case (idx)
                REG_INODE_LIMIT: search_limit[0] = data;
                REG_BLOCK_LIMIT: search_limit[1] = data;
                REG_FREE_INODES: free_base[0]    = data;
                REG_FREE_BLOCKS: free_base[1]    = data;
                default: ;
            endcase
        endfunction

        function void note_request(op_t kind, logic sel, logic [IDX_W-1:0] idx);
            alloc_result_t exp_r;
            int            lim;
            int            pos;
            int            i;
            int            w;
            exp_r = '0;
            pos   = int'(idx) % MAP_BITS;
            case (kind)
                OP_ALLOC:
                begin
                    lim = (search_limit[sel] > MAP_BITS) ? MAP_BITS : int'(search_limit[sel]);
                    for (i = 0; i < lim; i++)
                    begin
                        w = word_addr(sel, i);
                        if (!map_words[w][i % WORD_BITS])
                        begin
                            map_words[w][i % WORD_BITS] = 1'b1;
                            exp_r.alloc_number = CNT_W'(i + 1);
                            exp_r.found        = 1'b1;
                            if (alloc_count[sel] != CNT_MAX)
                                alloc_count[sel] = alloc_count[sel] + 1'b1;
                            break;
                        end
                    end
                end
                OP_TEST:
                    exp_r.bit_value = map_words[word_addr(sel, pos)][pos % WORD_BITS];
                OP_SET:
                    map_words[word_addr(sel, pos)][pos % WORD_BITS] = 1'b1;
                default:
                    map_words[word_addr(sel, pos)][pos % WORD_BITS] = 1'b0;
            endcase
            exp_r.free_left = (free_base[sel] > alloc_count[sel]) ?
                              free_base[sel] - alloc_count[sel] : '0;
            pending_results.push_back(exp_r);
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t exp_r;
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: alloc_number %0d found %0b",
                       got.alloc_number, got.found);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.alloc_number !== exp_r.alloc_number)
            begin
                $error("alloc_number expected %0d actual %0d",
                       exp_r.alloc_number, got.alloc_number);
                errors++;
            end
            if (got.found !== exp_r.found)
            begin
                $error("found expected %0b actual %0b", exp_r.found, got.found);
                errors++;
            end
            if (got.bit_value !== exp_r.bit_value)
            begin
                $error("bit_value expected %0b actual %0b", exp_r.bit_value, got.bit_value);
                errors++;
            end
            if (got.free_left !== exp_r.free_left)
            begin
                $error("free_left expected %0d actual %0d", exp_r.free_left, got.free_left);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

    endclass

endpackage

@@ tb/sv/tb_bitmap_first_free_allocator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_first_free_allocator
// Self-checking bench for the two-pool first-free bitmap allocator. A short
// directed sequence covers allocate, test, set and clear, zero and oversized
// limits, a full pool and free count saturation. Random phases with varying
// sender gaps and configurations follow, then a preload of the low block
// bits under a small limit and a short allocate/clear run on one inode bit.
// Each result transaction is checked against the tracker in order.
// ----------------------------------------------------------------------------
module tb_bitmap_first_free_allocator;

    import bffa_pkg::*;
    import alloc_scoreboard_pkg::*;

    localparam int TIMEOUT_NS   = 25_000_000;
    localparam int PHASE_ITEMS  = 130;
    localparam int PHASE_COUNT  = 8;
    localparam int FILL_BITS    = 64;
    localparam int CHURN_ROUNDS = 20;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [OP_W-1:0]      op;
    logic                 pool;
    logic [IDX_W-1:0]     bit_index;
    logic                 done;
    logic [CNT_W-1:0]     alloc_number;
    logic                 found;
    logic                 bit_value;
    logic [CNT_W-1:0]     free_left;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_data;

    alloc_scoreboard sb;
    int              idle_pct;
    int              idle_plan [4] = '{0, 78, 0, 9};

    bitmap_first_free_allocator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .pool         (pool),
        .bit_index    (bit_index),
        .done         (done),
        .alloc_number (alloc_number),
        .found        (found),
        .bit_value    (bit_value),
        .free_left    (free_left),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        alloc_result_t seen;
        if (rst_n && done)
        begin
            seen.alloc_number = alloc_number;
            seen.found        = found;
            seen.bit_value    = bit_value;
            seen.free_left    = free_left;
            sb.check_result(seen);
        end
    end

    task automatic issue_request(op_t kind, logic sel, logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        op        <= kind;
        pool      <= sel;
        bit_index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(kind, sel, idx);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(cfg_idx_t idx, logic [CNT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(input logic [CNT_W-1:0] ilim, blim, ifree, bfree);
        write_register(REG_INODE_LIMIT, ilim);
        write_register(REG_BLOCK_LIMIT, blim);
        write_register(REG_FREE_INODES, ifree);
        write_register(REG_FREE_BLOCKS, bfree);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CNT_W-1:0] pick_limit();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CNT_W'(1);
            2:       return CNT_W'(32);
            3:       return CNT_W'(33);
            4:       return CFG_RESET;
            5:       return CNT_MAX;
            default: return CNT_W'($urandom_range(300, 2));
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_free();
        case ($urandom_range(5))
            0:       return '0;
            1:       return CFG_RESET;
            2:       return CNT_MAX;
            default: return CNT_W'($urandom_range(600));
        endcase
    endfunction

    task automatic random_request();
        int               r;
        int               w;
        op_t              kind;
        logic             sel;
        logic [IDX_W-1:0] idx;
        r    = $urandom_range(9);
        kind = (r < 4) ? OP_ALLOC : op_t'(r % 3 + 1);
        sel  = 1'($urandom_range(1));
        w    = int'(sb.search_limit[sel]);
        if (w > MAP_BITS - 65)
            w = MAP_BITS - 65;
        if ($urandom_range(9) < 7)
            idx = IDX_W'($urandom_range(w + 64));
        else
            idx = IDX_W'($urandom);
        issue_request(kind, sel, idx);
    endtask

    initial
    begin
        int ph;
        int n;
        int b;
        sb        = new();
        idle_pct  = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        op        = OP_ALLOC;
        pool      = 1'b0;
        bit_index = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_INODE_LIMIT;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // written while the clearing pass runs
        configure(CFG_RESET, CFG_RESET, CFG_RESET, CFG_RESET);

        issue_request(OP_TEST,  1'b0, '0);
        issue_request(OP_TEST,  1'b1, {IDX_W{1'b1}});
        issue_request(OP_ALLOC, 1'b0, '0);
        issue_request(OP_ALLOC, 1'b1, {IDX_W{1'b1}});
        issue_request(OP_SET,   1'b0, IDX_W'(1));
        issue_request(OP_ALLOC, 1'b0, '0);
        issue_request(OP_TEST,  1'b0, IDX_W'(1));
        issue_request(OP_SET,   1'b1, {IDX_W{1'b1}});
        issue_request(OP_TEST,  1'b1, {IDX_W{1'b1}});
        issue_request(OP_CLEAR, 1'b1, {IDX_W{1'b1}});
        issue_request(OP_TEST,  1'b1, {IDX_W{1'b1}});
        issue_request(OP_CLEAR, 1'b0, '0);
        issue_request(OP_ALLOC, 1'b0, '0);
        drain_results();

        // zero limit, tiny block pool, free counts below allocations
        configure('0, CNT_W'(2), '0, CNT_W'(1));
        issue_request(OP_ALLOC, 1'b0, '0);
        issue_request(OP_ALLOC, 1'b1, '0);
        issue_request(OP_ALLOC, 1'b1, '0);
        issue_request(OP_SET,   1'b1, IDX_W'(5));
        issue_request(OP_CLEAR, 1'b1, '0);
        drain_results();

        configure(CNT_MAX, CFG_RESET, CNT_MAX, CFG_RESET);
        issue_request(OP_ALLOC, 1'b0, '0);
        issue_request(OP_ALLOC, 1'b1, '0);
        issue_request(OP_TEST,  1'b0, IDX_W'(13'h1555));
        issue_request(OP_SET,   1'b0, IDX_W'(13'h0AAA));
        issue_request(OP_TEST,  1'b0, IDX_W'(13'h0AAA));
        drain_results();

        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            configure(pick_limit(), pick_limit(), pick_free(), pick_free());
            idle_pct = idle_plan[ph % 4];
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(49) == 0)
                    drain_results();
                random_request();
            end
            drain_results();
        end

        // fill the low block bits, then probe the full and last-bit cases
        idle_pct = 0;
        configure(CNT_W'(FILL_BITS), CNT_W'(FILL_BITS), CFG_RESET, CNT_MAX);
        for (b = 0; b < FILL_BITS; b++)
            issue_request(OP_SET, 1'b1, IDX_W'(b));
        issue_request(OP_ALLOC, 1'b1, '0);
        issue_request(OP_CLEAR, 1'b1, IDX_W'(FILL_BITS - 1));
        issue_request(OP_ALLOC, 1'b1, '0);
        issue_request(OP_ALLOC, 1'b1, '0);
        idle_pct = 9;
        for (n = 0; n < 20; n++)
        begin
            b = $urandom_range(FILL_BITS - 1);
            issue_request(OP_CLEAR, 1'b1, IDX_W'(b));
            issue_request(OP_TEST,  1'b1, IDX_W'(b));
            issue_request(OP_ALLOC, 1'b1, '0);
        end
        drain_results();

        // alloc and release bit 0 over and over
        idle_pct = 0;
        configure(CNT_W'(1), CFG_RESET, CNT_MAX, CFG_RESET);
        issue_request(OP_CLEAR, 1'b0, '0);
        for (n = 0; n < CHURN_ROUNDS; n++)
        begin
            issue_request(OP_ALLOC, 1'b0, '0);
            issue_request(OP_CLEAR, 1'b0, '0);
        end
        issue_request(OP_TEST,  1'b0, '0);
        issue_request(OP_ALLOC, 1'b0, '0);
        issue_request(OP_ALLOC, 1'b0, '0);
        drain_results();

        repeat (300) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
